// ===== hw/rtl/sle_pkg.sv =====
// Shared constants, codes and control structs of the sorted link table engine.
package sle_pkg;

	localparam int DEPTH  = 65536;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = AW + 1;
	localparam int ID_W   = 56;
	localparam int PAIR_W = 2 * ID_W;
	localparam int OUT_W  = 17;

	localparam logic [1:0] KIND_PUSH   = 2'd0;
	localparam logic [1:0] KIND_MARK   = 2'd1;
	localparam logic [1:0] KIND_SORT   = 2'd2;
	localparam logic [1:0] KIND_SEARCH = 2'd3;

	localparam logic [2:0] RS_ZERO = 3'd0;
	localparam logic [2:0] RS_LAST = 3'd1;
	localparam logic [2:0] RS_MID  = 3'd2;
	localparam logic [2:0] RS_I    = 3'd3;
	localparam logic [2:0] RS_A    = 3'd4;
	localparam logic [2:0] RS_B    = 3'd5;
	localparam logic [2:0] RS_TAKE = 3'd6;

	typedef struct packed {
		logic       in_ready;
		logic       push0;
		logic       push1;
		logic       set_ovf;
		logic       mark_set;
		logic       pos_count;
		logic       pos_hi;
		logic       bisect;
		logic       c_step;
		logic       c_done;
		logic       pass_done;
		logic       blk_init;
		logic       blk_next;
		logic       mrg_take;
		logic       ld_a;
		logic       ld_b;
		logic       out_load;
		logic [2:0] rsel;
	} cmd_t;

	typedef struct packed {
		logic       in_fire;
		logic [1:0] kind;
		logic       count_zero;
		logic       push_full;
		logic       idx_in;
		logic       below;
		logic       span_gt1;
		logic       i_lt_n;
		logic       lo_ge_n;
		logic       width_lt_n;
		logic       a_lt_mid;
		logic       b_lt_hi;
		logic       take_a;
		logic       out_busy;
	} sts_t;

endpackage

// ===== hw/rtl/sle_if.sv =====
// Input and result channel interfaces of the sorted link table engine.
interface sle_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [55:0] first_id;
	logic [55:0] second_id;
	logic [15:0] entry_index;
	logic [11:0] search_slab;
	logic [11:0] search_row;
	modport source(output valid, kind, first_id, second_id, entry_index, search_slab,
		search_row, input ready);
	modport sink(input valid, kind, first_id, second_id, entry_index, search_slab,
		search_row, output ready);
endinterface

interface sle_out_if;
	logic        valid;
	logic        ready;
	logic [16:0] position;
	logic [16:0] table_length;
	logic        overflow;
	modport source(output valid, position, table_length, overflow, input ready);
	modport sink(input valid, position, table_length, overflow, output ready);
endinterface

// ===== hw/rtl/sle_ram.sv =====
// Generic single write port RAM with registered read.
module sle_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/sle_datapath.sv =====
// Datapath: table banks, mark store, counters, search and merge registers.
module sle_datapath (
	input  logic         clk,
	input  logic         arst_n,
	sle_in_if.sink       in_ch,
	sle_out_if.source    out_ch,
	input  sle_pkg::cmd_t cmd,
	output sle_pkg::sts_t sts
);
	import sle_pkg::*;

	logic [1:0]      kind_q;
	logic [ID_W-1:0] a_q, b_q, key_q;
	logic [15:0]     idx_q;
	logic [CW-1:0]   count_q, lo_q, hi_q, i_q, k_q, mmid_q, ma_q, mb_q, width_q, pos_q;
	logic            cur_q, ovf_q;
	logic [PAIR_W-1:0] ha_q, hb_q;
	logic            out_valid_q, out_ovf_q;
	logic [OUT_W-1:0] out_pos_q, out_len_q;

	logic [CW-1:0]   smid, bmid, bhi, last;
	logic [AW-1:0]   raddr, pw_addr, mk_addr;
	logic [PAIR_W-1:0] rd0, rd1, rd_pair, pw_data;
	logic            pw_en, pw_bank, mk_we, mk_d, mk_rd, take_a, fire;

	assign fire    = in_ch.valid & in_ch.ready;
	assign last    = count_q - CW'(1);
	assign smid    = lo_q + ((hi_q - lo_q) >> 1);
	assign bmid    = (lo_q + width_q < count_q) ? lo_q + width_q : count_q;
	assign bhi     = (mmid_q + width_q < count_q) ? mmid_q + width_q : count_q;
	assign rd_pair = cur_q ? rd1 : rd0;
	assign take_a  = (mb_q >= hi_q) ||
		((ma_q < mmid_q) && (ha_q[PAIR_W-1 -: ID_W] <= hb_q[PAIR_W-1 -: ID_W]));

	always_comb begin
		case (cmd.rsel)
			RS_ZERO: raddr = '0;
			RS_LAST: raddr = last[AW-1:0];
			RS_MID:  raddr = smid[AW-1:0];
			RS_I:    raddr = i_q[AW-1:0];
			RS_A:    raddr = ma_q[AW-1:0];
			RS_B:    raddr = mb_q[AW-1:0];
			RS_TAKE: raddr = take_a ? ma_q[AW-1:0] + AW'(1) : mb_q[AW-1:0] + AW'(1);
			default: raddr = '0;
		endcase
	end

	// one write per cycle into the pair banks and the mark store
	always_comb begin
		pw_en   = 1'b0;
		pw_bank = ~cur_q;
		pw_addr = k_q[AW-1:0];
		pw_data = rd_pair;
		mk_we   = 1'b0;
		mk_addr = k_q[AW-1:0];
		mk_d    = 1'b0;
		if (cmd.push0) begin
			pw_en   = 1'b1;
			pw_bank = cur_q;
			pw_addr = count_q[AW-1:0];
			pw_data = {a_q, b_q};
			mk_we   = 1'b1;
			mk_addr = count_q[AW-1:0];
		end else if (cmd.push1) begin
			pw_en   = 1'b1;
			pw_bank = cur_q;
			pw_addr = count_q[AW-1:0] + AW'(1);
			pw_data = {b_q, a_q};
			mk_we   = 1'b1;
			mk_addr = count_q[AW-1:0] + AW'(1);
		end else if (cmd.mark_set) begin
			mk_we   = 1'b1;
			mk_addr = AW'(idx_q);
			mk_d    = 1'b1;
		end else if (cmd.c_step) begin
			pw_en = ~mk_rd;
			mk_we = ~mk_rd;
		end else if (cmd.mrg_take) begin
			pw_en   = 1'b1;
			pw_data = take_a ? ha_q : hb_q;
		end
	end

	sle_ram #(.W(PAIR_W), .D(DEPTH)) u_bank0 (
		.clk(clk), .we(pw_en & ~pw_bank), .waddr(pw_addr), .wdata(pw_data),
		.raddr(raddr), .rdata(rd0)
	);
	sle_ram #(.W(PAIR_W), .D(DEPTH)) u_bank1 (
		.clk(clk), .we(pw_en & pw_bank), .waddr(pw_addr), .wdata(pw_data),
		.raddr(raddr), .rdata(rd1)
	);
	sle_ram #(.W(1), .D(DEPTH)) u_marks (
		.clk(clk), .we(mk_we), .waddr(mk_addr), .wdata(mk_d),
		.raddr(raddr), .rdata(mk_rd)
	);

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q <= in_ch.kind;
			a_q    <= in_ch.first_id;
			b_q    <= in_ch.second_id;
			idx_q  <= in_ch.entry_index;
			key_q  <= {in_ch.search_slab, in_ch.search_row, 32'd0};
		end
		if (cmd.ld_a) ha_q <= rd_pair;
		if (cmd.ld_b) hb_q <= rd_pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_q       <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			k_q         <= '0;
			mmid_q      <= '0;
			ma_q        <= '0;
			mb_q        <= '0;
			width_q     <= '0;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_pos_q   <= '0;
			out_len_q   <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (fire) begin
				pos_q <= '0;
				ovf_q <= 1'b0;
				lo_q  <= '0;
				hi_q  <= last;
				i_q   <= '0;
				k_q   <= '0;
			end
			if (cmd.set_ovf)   ovf_q   <= 1'b1;
			if (cmd.push1)     count_q <= count_q + CW'(2);
			if (cmd.pos_count) pos_q   <= count_q;
			if (cmd.pos_hi)    pos_q   <= hi_q;
			if (cmd.bisect) begin
				if (sts.below) lo_q <= smid;
				else hi_q <= smid;
			end
			if (cmd.c_step) begin
				i_q <= i_q + CW'(1);
				if (!mk_rd) k_q <= k_q + CW'(1);
			end
			if (cmd.c_done) begin
				count_q <= k_q;
				cur_q   <= ~cur_q;
				width_q <= CW'(1);
				lo_q    <= '0;
			end
			if (cmd.pass_done) begin
				cur_q   <= ~cur_q;
				width_q <= width_q << 1;
				lo_q    <= '0;
			end
			if (cmd.blk_init) begin
				mmid_q <= bmid;
				ma_q   <= lo_q;
				mb_q   <= bmid;
				k_q    <= lo_q;
				hi_q   <= (bmid + width_q < count_q) ? bmid + width_q : count_q;
			end
			if (cmd.blk_next) lo_q <= hi_q;
			if (cmd.mrg_take) begin
				k_q <= k_q + CW'(1);
				if (take_a) ma_q <= ma_q + CW'(1);
				else mb_q <= mb_q + CW'(1);
			end
			// hold the result until the beat is taken
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				out_pos_q   <= OUT_W'(pos_q);
				out_len_q   <= OUT_W'(count_q);
				out_ovf_q   <= ovf_q;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ch.ready         = cmd.in_ready;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.position     = out_pos_q;
	assign out_ch.table_length = out_len_q;
	assign out_ch.overflow     = out_ovf_q;

	assign sts.in_fire    = fire;
	assign sts.kind       = fire ? in_ch.kind : kind_q;
	assign sts.count_zero = (count_q == '0);
	assign sts.push_full  = ((CW+1)'(count_q) + (CW+1)'(2)) > (CW+1)'(DEPTH);
	assign sts.idx_in     = 32'(idx_q) < 32'(count_q);
	assign sts.below      = mk_rd | (rd_pair[PAIR_W-1 -: ID_W] < key_q);
	assign sts.span_gt1   = (hi_q - lo_q) > CW'(1);
	assign sts.i_lt_n     = i_q < count_q;
	assign sts.lo_ge_n    = lo_q >= count_q;
	assign sts.width_lt_n = width_q < count_q;
	assign sts.a_lt_mid   = ma_q < mmid_q;
	assign sts.b_lt_hi    = mb_q < hi_q;
	assign sts.take_a     = take_a;
	assign sts.out_busy   = out_valid_q & ~out_ch.ready;

	unused_bhi: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.blk_init |=> hi_q == bhi)
		else $error("merge block end mismatch");
	count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond table depth");
	ovf_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_ovf |=> $stable(count_q))
		else $error("dropped push changed the table");
	push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push1 |=> count_q == $past(count_q) + CW'(2))
		else $error("push did not add two entries");
	bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bisect |=> lo_q <= hi_q)
		else $error("search bounds crossed");
endmodule

// ===== hw/rtl/sle_ctrl.sv =====
// Controller state machine sequencing push, mark, compact-and-sort and search.
module sle_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  sle_pkg::sts_t sts,
	output sle_pkg::cmd_t cmd
);
	import sle_pkg::*;

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_PUSH0  = 5'd1;
	localparam logic [4:0] ST_PUSH1  = 5'd2;
	localparam logic [4:0] ST_MARK   = 5'd3;
	localparam logic [4:0] ST_LO_RD  = 5'd4;
	localparam logic [4:0] ST_LO_EV  = 5'd5;
	localparam logic [4:0] ST_HI_RD  = 5'd6;
	localparam logic [4:0] ST_HI_EV  = 5'd7;
	localparam logic [4:0] ST_MID    = 5'd8;
	localparam logic [4:0] ST_MID_RD = 5'd9;
	localparam logic [4:0] ST_MID_EV = 5'd10;
	localparam logic [4:0] ST_C_RD   = 5'd11;
	localparam logic [4:0] ST_C_EV   = 5'd12;
	localparam logic [4:0] ST_PASS   = 5'd13;
	localparam logic [4:0] ST_BLK    = 5'd14;
	localparam logic [4:0] ST_RA     = 5'd15;
	localparam logic [4:0] ST_RB     = 5'd16;
	localparam logic [4:0] ST_LB     = 5'd17;
	localparam logic [4:0] ST_MRG    = 5'd18;
	localparam logic [4:0] ST_LA     = 5'd19;
	localparam logic [4:0] ST_FIN    = 5'd20;

	logic [4:0] state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_fire) begin
					case (sts.kind)
						KIND_PUSH: state_d = ST_PUSH0;
						KIND_MARK: state_d = ST_MARK;
						KIND_SORT: state_d = ST_C_RD;
						default:   state_d = ST_LO_RD;
					endcase
				end
			end
			ST_PUSH0: begin
				if (sts.push_full) begin
					cmd.set_ovf = 1'b1;
					state_d     = ST_FIN;
				end else begin
					cmd.push0 = 1'b1;
					state_d   = ST_PUSH1;
				end
			end
			ST_PUSH1: begin
				cmd.push1 = 1'b1;
				state_d   = ST_FIN;
			end
			ST_MARK: begin
				cmd.mark_set = sts.idx_in;
				state_d      = ST_FIN;
			end
			ST_LO_RD: begin
				cmd.rsel = RS_ZERO;
				state_d  = sts.count_zero ? ST_FIN : ST_LO_EV;
			end
			ST_LO_EV: state_d = sts.below ? ST_HI_RD : ST_FIN;
			ST_HI_RD: begin
				cmd.rsel = RS_LAST;
				state_d  = ST_HI_EV;
			end
			ST_HI_EV: begin
				if (sts.below) begin
					cmd.pos_count = 1'b1;
					state_d       = ST_FIN;
				end else begin
					state_d = ST_MID;
				end
			end
			ST_MID: begin
				if (sts.span_gt1) begin
					state_d = ST_MID_RD;
				end else begin
					cmd.pos_hi = 1'b1;
					state_d    = ST_FIN;
				end
			end
			ST_MID_RD: begin
				cmd.rsel = RS_MID;
				state_d  = ST_MID_EV;
			end
			ST_MID_EV: begin
				cmd.bisect = 1'b1;
				state_d    = ST_MID;
			end
			ST_C_RD: begin
				if (sts.i_lt_n) begin
					cmd.rsel = RS_I;
					state_d  = ST_C_EV;
				end else begin
					cmd.c_done = 1'b1;
					state_d    = ST_PASS;
				end
			end
			ST_C_EV: begin
				cmd.c_step = 1'b1;
				state_d    = ST_C_RD;
			end
			ST_PASS: state_d = sts.width_lt_n ? ST_BLK : ST_FIN;
			ST_BLK: begin
				if (sts.lo_ge_n) begin
					cmd.pass_done = 1'b1;
					state_d       = ST_PASS;
				end else begin
					cmd.blk_init = 1'b1;
					state_d      = ST_RA;
				end
			end
			ST_RA: begin
				cmd.rsel = RS_A;
				state_d  = ST_RB;
			end
			ST_RB: begin
				cmd.ld_a = 1'b1;
				cmd.rsel = RS_B;
				state_d  = ST_LB;
			end
			ST_LB: begin
				cmd.ld_b = 1'b1;
				state_d  = ST_MRG;
			end
			ST_MRG: begin
				if (sts.a_lt_mid || sts.b_lt_hi) begin
					cmd.mrg_take = 1'b1;
					cmd.rsel     = RS_TAKE;
					state_d      = sts.take_a ? ST_LA : ST_LB;
				end else begin
					cmd.blk_next = 1'b1;
					state_d      = ST_BLK;
				end
			end
			ST_LA: begin
				cmd.ld_a = 1'b1;
				state_d  = ST_MRG;
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == ST_IDLE)
		else $error("result loaded outside finish");
	one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push0, cmd.push1, cmd.mark_set, cmd.c_step, cmd.mrg_take}))
		else $error("two table writes in one cycle");
	accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sts.in_fire |-> state_q == ST_IDLE)
		else $error("beat accepted while busy");
endmodule

// ===== hw/rtl/sorted_link_table_engine_unit.sv =====
// Top level of the sorted link table engine: controller plus datapath.
// Usage: one input beat on in_ch carries a command (push pair, mark entry,
// compact and sort, search); exactly one result beat follows on out_ch with
// position, table_length and overflow. Items are handled one at a time:
// in_ch.ready is high only while the engine is idle.
// Each search probe wraps one registered table read in the states
// ST_MID, ST_MID_RD and ST_MID_EV.
// Compact and sort walks the table once, then runs a bottom-up merge sort
// between two table banks in ceil(log2(length)) passes; each bank has a
// single read port.
// Reset clears the entry count and the control state; the table contents
// are not cleared and need no clearing pass.
// The result sits in an output register; when the receiver stalls, the
// engine finishes the current item and waits with it until the slot frees,
// and a new beat may be accepted while a finished result is still waiting.
module sorted_link_table_engine_unit (
	input  logic      clk,
	input  logic      arst_n,
	sle_in_if.sink    in_ch,
	sle_out_if.source out_ch
);
	import sle_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sle_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd)
	);

	sle_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cmd(cmd), .sts(sts)
	);
endmodule
